// File: src/ssl_pkg.sv
package ssl_pkg;

    // command codes
    typedef enum logic [2:0] {
        CMD_INIT     = 3'd0,
        CMD_PUBLISH  = 3'd1,
        CMD_FIND     = 3'd2,
        CMD_ACTIVATE = 3'd3,
        CMD_CLOSE    = 3'd4,
        CMD_REMOVE   = 3'd5,
        CMD_SHUTDOWN = 3'd6
    } cmd_t;

    // slot lifecycle phase
    typedef enum logic [1:0] {
        PH_FREE   = 2'd0,
        PH_EST    = 2'd1,
        PH_ACT    = 2'd2,
        PH_CLOSED = 2'd3
    } phase_t;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_BAD_STATE = 2'd2;
    localparam logic [1:0] ST_LIMIT     = 2'd3;

    // per-cell update operations
    typedef enum logic [2:0] {
        CELL_NOP   = 3'd0,
        CELL_ALLOC = 3'd1,
        CELL_PHASE = 3'd2,
        CELL_FREE  = 3'd3,
        CELL_CLEAR = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        phase_t   phase;
    } cell_cmd_t;

    localparam logic [4:0] CAP_RESET = 5'd16;

endpackage

// File: src/ssl_cell.sv
module ssl_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDX_BITS = 4,
    parameter int CNT_BITS = 5,
    parameter int ID_BITS  = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ssl_pkg::cell_cmd_t    cmd,
    input  logic [IDX_BITS-1:0]   wr_idx,
    input  logic [ID_BITS-1:0]    key,
    input  logic [CNT_BITS-1:0]   cap,
    input  logic                  hit_in,
    input  logic                  free_in,
    output logic                  hit_out,
    output logic                  free_out,
    output logic                  first_hit,
    output logic                  first_free,
    output ssl_pkg::phase_t       phase,
    output logic [ID_BITS-1:0]    ident
);
    import ssl_pkg::*;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [ID_BITS-1:0]  ident_reg;
    logic [ID_BITS-1:0]  ident_next;
    logic                usable;
    logic                occ;
    logic                match;
    logic                sel;

    // slot lookup, chained through the row
    always_comb
    begin
        usable     = (CELL_IDX < 32'(cap));
        occ        = (phase_reg != PH_FREE);
        match      = usable && occ && (ident_reg == key);
        first_hit  = match && !hit_in;
        hit_out    = hit_in || match;
        first_free = usable && !occ && !free_in;
        free_out   = free_in || (usable && !occ);
        phase      = phase_reg;
        ident      = ident_reg;
    end

    // slot update
    always_comb
    begin
        sel        = (32'(wr_idx) == CELL_IDX);
        phase_next = phase_reg;
        ident_next = ident_reg;
        unique case (cmd.op)
            CELL_ALLOC:
            begin
                if (sel)
                begin
                    phase_next = PH_EST;
                    ident_next = key;
                end
            end
            CELL_PHASE:
            begin
                if (sel)
                    phase_next = cmd.phase;
            end
            CELL_FREE:
            begin
                if (sel)
                    phase_next = PH_FREE;
            end
            CELL_CLEAR: phase_next = PH_FREE;
            default:    phase_next = phase_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_FREE;
        else
            phase_reg <= phase_next;
    end

    // ident is only read while the slot is occupied
    always_ff @(posedge clk)
    begin
        ident_reg <= ident_next;
    end

endmodule

// File: src/session_slot_table.sv
// session_slot_table: a row of session slot cells with ID lookup and allocation.
// Command channel: start with command and session_id; a command is taken at a
// clock edge with start high and busy low. busy stays high until the result
// has been computed.
// Result channel: done pulses for one cycle with status, result_id, slot_index,
// slot_status and found. The receiver cannot stall; each result is final.
// Sequencing: an accepted command is registered and then runs in the execute
// state; publish repeats the execute state for each ID collision, at most
// once per occupied slot. Lookup compares the key in every cell
// combinationally, with the first-hit and first-free flags rippling along the row.
// A new command can be accepted in the cycle that done is high.
// Configuration: capacity_in_use is written when capacity_in_use_we is high;
// it takes effect at the next init command and is clamped to SLOTS.
// Reset: all slots free, table not initialized, next ID one, capacity 16,
// latched capacity zero. No clearing pass is needed.
module session_slot_table #(
    parameter int SLOTS   = 16,
    parameter int ID_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [31:0] session_id,
    input  logic        capacity_in_use_we,
    input  logic [4:0]  capacity_in_use,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] result_id,
    output logic [3:0]  slot_index,
    output logic [1:0]  slot_status,
    output logic        found
);
    import ssl_pkg::*;

    localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_BITS = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [4:0]           cfg_reg;
    logic [CNT_BITS-1:0]  cap_reg, cap_next;
    logic                 ready_reg, ready_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [CNT_BITS-1:0]  coll_reg, coll_next;
    logic [ID_BITS-1:0]   nid_reg, nid_next;
    logic [2:0]           cmd_reg;
    logic [ID_BITS-1:0]   key_reg, key_next;
    logic                 zero_reg, wide_reg;
    logic                 done_reg, done_next;
    logic [1:0]           status_reg, status_next;
    logic [ID_BITS-1:0]   rid_reg, rid_next;
    logic [IDX_BITS-1:0]  ridx_reg, ridx_next;
    logic [1:0]           rph_reg, rph_next;
    logic                 found_reg, found_next;

    cell_cmd_t            ccmd;
    logic [IDX_BITS-1:0]  wr_idx;
    logic [SLOTS:0]       hit_chain;
    logic [SLOTS:0]       free_chain;
    logic [SLOTS-1:0]     c_hit, c_free;
    phase_t               c_phase [SLOTS];
    logic [ID_BITS-1:0]   c_ident [SLOTS];
    logic                 hit_any, free_any;
    logic [IDX_BITS-1:0]  hit_idx, free_idx;
    logic [1:0]           hit_phase;
    logic [ID_BITS-1:0]   hit_ident;
    logic [ID_BITS-1:0]   key_inc;
    logic                 accept;

    assign accept        = start && (state_reg == S_IDLE);
    assign hit_chain[0]  = 1'b0;
    assign free_chain[0] = 1'b0;

    // row of slot cells
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        ssl_cell #(
            .CELL_IDX (i),
            .IDX_BITS (IDX_BITS),
            .CNT_BITS (CNT_BITS),
            .ID_BITS  (ID_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (ccmd),
            .wr_idx     (wr_idx),
            .key        (key_reg),
            .cap        (cap_reg),
            .hit_in     (hit_chain[i]),
            .free_in    (free_chain[i]),
            .hit_out    (hit_chain[i+1]),
            .free_out   (free_chain[i+1]),
            .first_hit  (c_hit[i]),
            .first_free (c_free[i]),
            .phase      (c_phase[i]),
            .ident      (c_ident[i])
        );
    end

    // gather the first hit and first free slot
    always_comb
    begin
        hit_idx   = '0;
        free_idx  = '0;
        hit_phase = '0;
        hit_ident = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (c_hit[i])
            begin
                hit_idx   = hit_idx | IDX_BITS'(i);
                hit_phase = hit_phase | c_phase[i];
                hit_ident = hit_ident | c_ident[i];
            end
            if (c_free[i])
                free_idx = free_idx | IDX_BITS'(i);
        end
        hit_any  = hit_chain[SLOTS];
        free_any = free_chain[SLOTS];
        key_inc  = key_reg + 1'b1;
        if (key_inc == '0)
            key_inc = ID_BITS'(1);
    end

    // command sequencer
    always_comb
    begin
        state_next  = state_reg;
        cap_next    = cap_reg;
        ready_next  = ready_reg;
        count_next  = count_reg;
        coll_next   = coll_reg;
        nid_next    = nid_reg;
        key_next    = key_reg;
        done_next   = 1'b0;
        status_next = ST_OK;
        rid_next    = '0;
        ridx_next   = '0;
        rph_next    = '0;
        found_next  = 1'b0;
        ccmd.op     = CELL_NOP;
        ccmd.phase  = PH_FREE;
        wr_idx      = hit_idx;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    coll_next  = '0;
                    state_next = S_EXEC;
                    if (cmd_t'(command) == CMD_PUBLISH)
                        key_next = (nid_reg == '0) ? ID_BITS'(1) : nid_reg;
                    else
                        key_next = ID_BITS'(session_id);
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                unique case (cmd_reg)
                    CMD_INIT:
                    begin
                        if (ready_reg)
                            status_next = ST_BAD_STATE;
                        else
                        begin
                            ccmd.op    = CELL_CLEAR;
                            count_next = '0;
                            nid_next   = ID_BITS'(1);
                            cap_next   = (32'(cfg_reg) > SLOTS) ? CNT_BITS'(SLOTS)
                                                                 : CNT_BITS'(cfg_reg);
                            ready_next = 1'b1;
                        end
                    end
                    CMD_SHUTDOWN:
                    begin
                        ccmd.op    = CELL_CLEAR;
                        count_next = '0;
                        nid_next   = ID_BITS'(1);
                        cap_next   = '0;
                        ready_next = 1'b0;
                    end
                    CMD_FIND, CMD_ACTIVATE, CMD_CLOSE:
                    begin
                        if (!ready_reg || zero_reg || wide_reg || !hit_any)
                            status_next = ST_NOT_FOUND;
                        else
                        begin
                            found_next = 1'b1;
                            rid_next   = hit_ident;
                            ridx_next  = hit_idx;
                            rph_next   = hit_phase;
                            if (cmd_reg == CMD_ACTIVATE)
                            begin
                                if (phase_t'(hit_phase) != PH_EST)
                                    status_next = ST_BAD_STATE;
                                else
                                begin
                                    ccmd.op    = CELL_PHASE;
                                    ccmd.phase = PH_ACT;
                                    rph_next   = PH_ACT;
                                end
                            end
                            else if (cmd_reg == CMD_CLOSE)
                            begin
                                ccmd.op    = CELL_PHASE;
                                ccmd.phase = PH_CLOSED;
                                rph_next   = PH_CLOSED;
                            end
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (zero_reg)
                            status_next = ST_NOT_FOUND;
                        else if (!ready_reg)
                            status_next = ST_BAD_STATE;
                        else if (wide_reg || !hit_any)
                            status_next = ST_NOT_FOUND;
                        else
                        begin
                            ccmd.op    = CELL_FREE;
                            found_next = 1'b1;
                            rid_next   = hit_ident;
                            ridx_next  = hit_idx;
                            rph_next   = PH_FREE;
                            if (count_reg != '0)
                                count_next = count_reg - 1'b1;
                        end
                    end
                    CMD_PUBLISH:
                    begin
                        if (!ready_reg)
                            status_next = ST_BAD_STATE;
                        else if (count_reg >= cap_reg)
                            status_next = ST_LIMIT;
                        else if (!free_any)
                            status_next = ST_BAD_STATE;
                        else if (hit_any)
                        begin
                            // ID collision: try the next candidate
                            if (coll_reg >= count_reg)
                                status_next = ST_LIMIT;
                            else
                            begin
                                coll_next  = coll_reg + 1'b1;
                                key_next   = key_inc;
                                state_next = S_EXEC;
                                done_next  = 1'b0;
                            end
                        end
                        else
                        begin
                            ccmd.op    = CELL_ALLOC;
                            wr_idx     = free_idx;
                            count_next = count_reg + 1'b1;
                            nid_next   = key_inc;
                            found_next = 1'b1;
                            rid_next   = key_reg;
                            ridx_next  = free_idx;
                            rph_next   = PH_EST;
                        end
                    end
                    default: status_next = ST_NOT_FOUND;
                endcase
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cfg_reg   <= CAP_RESET;
            cap_reg   <= '0;
            ready_reg <= 1'b0;
            count_reg <= '0;
            coll_reg  <= '0;
            nid_reg   <= ID_BITS'(1);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (capacity_in_use_we)
                cfg_reg <= capacity_in_use;
            cap_reg   <= cap_next;
            ready_reg <= ready_next;
            count_reg <= count_next;
            coll_reg  <= coll_next;
            nid_reg   <= nid_next;
            done_reg  <= done_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (accept)
        begin
            cmd_reg  <= command;
            zero_reg <= (session_id == '0);
            wide_reg <= ((session_id >> ID_BITS) != '0);
        end
        status_reg <= status_next;
        rid_reg    <= rid_next;
        ridx_reg   <= ridx_next;
        rph_reg    <= rph_next;
        found_reg  <= found_next;
    end

    // result beat
    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign result_id   = 32'(rid_reg);
    assign slot_index  = 4'(ridx_reg);
    assign slot_status = rph_reg;
    assign found       = found_reg;

`ifndef SYNTHESIS
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EXEC))
        else $error("result without execute cycle");
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (result_id == '0 && slot_index == '0 && slot_status == '0))
        else $error("result fields set without a slot");
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_reg)
        else $error("occupied count above capacity");
    // collision count only means something while a command executes
    a_coll_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> (coll_reg <= count_reg))
        else $error("collision count above occupied count");
`endif

endmodule

// File: bench/session_slot_table_tb.sv
module session_slot_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssl_pkg::*;

    localparam int NSLOT = 16;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] rid;
        logic [3:0]  idx;
        logic [1:0]  phase;
        logic        hit;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  command = 3'd0;
    logic [31:0] session_id = 32'd0;
    logic        capacity_in_use_we = 1'b0;
    logic [4:0]  capacity_in_use = 5'd0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [31:0] result_id;
    logic [3:0]  slot_index;
    logic [1:0]  slot_status;
    logic        found;

    // shadow copy of the slot table
    logic [1:0]  tbl_phase [NSLOT];
    logic [31:0] tbl_id [NSLOT];
    int          occupied;
    logic [31:0] next_id;
    bit          ready;
    int          cap_latched;
    logic [4:0]  cap_reg;

    outcome_t    pending_results[$];
    int          failures = 0;
    int          idle_pct = 0;

    session_slot_table dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .session_id(session_id),
        .capacity_in_use_we(capacity_in_use_we), .capacity_in_use(capacity_in_use),
        .done(done), .status(status), .result_id(result_id),
        .slot_index(slot_index), .slot_status(slot_status), .found(found)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void clear_shadow();
        for (int i = 0; i < NSLOT; i++)
        begin
            tbl_phase[i] = PH_FREE;
            tbl_id[i] = '0;
        end
        occupied = 0;
        next_id = 32'd1;
    endfunction

    function automatic int slot_of(logic [31:0] id);
        for (int i = 0; i < cap_latched; i++)
            if (tbl_phase[i] != PH_FREE && tbl_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic outcome_t outcome(logic [1:0] st, int s);
        outcome_t o;
        o.status = st;
        o.rid = (s >= 0) ? tbl_id[s] : '0;
        o.idx = (s >= 0) ? s[3:0] : '0;
        o.phase = (s >= 0) ? tbl_phase[s] : '0;
        o.hit = (s >= 0);
        return o;
    endfunction

    function automatic outcome_t publish_session();
        int slot;
        int hits;
        logic [31:0] cand;
        slot = -1;
        hits = 0;
        if (!ready)
            return outcome(ST_BAD_STATE, -1);
        if (occupied >= cap_latched)
            return outcome(ST_LIMIT, -1);
        for (int i = 0; i < cap_latched; i++)
            if (slot < 0 && tbl_phase[i] == PH_FREE)
                slot = i;
        if (slot < 0)
            return outcome(ST_BAD_STATE, -1);
        cand = (next_id == 0) ? 32'd1 : next_id;
        while (slot_of(cand) >= 0)
        begin
            hits++;
            if (hits > occupied)
                return outcome(ST_LIMIT, -1);
            cand = cand + 1;
            if (cand == 0)
                cand = 32'd1;
        end
        tbl_id[slot] = cand;
        tbl_phase[slot] = PH_EST;
        occupied++;
        next_id = cand + 1;
        if (next_id == 0)
            next_id = 32'd1;
        return outcome(ST_OK, slot);
    endfunction

    // work out the result of one command and update the shadow table
    function automatic outcome_t table_apply(logic [2:0] cmd, logic [31:0] id);
        int s;
        outcome_t o;
        case (cmd)
            CMD_INIT:
            begin
                if (ready)
                    return outcome(ST_BAD_STATE, -1);
                clear_shadow();
                cap_latched = (cap_reg > NSLOT) ? NSLOT : int'(cap_reg);
                ready = 1'b1;
                return outcome(ST_OK, -1);
            end
            CMD_PUBLISH:
                return publish_session();
            CMD_FIND, CMD_ACTIVATE, CMD_CLOSE:
            begin
                if (!ready || id == 0)
                    return outcome(ST_NOT_FOUND, -1);
                s = slot_of(id);
                if (s < 0)
                    return outcome(ST_NOT_FOUND, -1);
                if (cmd == CMD_ACTIVATE)
                begin
                    if (tbl_phase[s] != PH_EST)
                        return outcome(ST_BAD_STATE, s);
                    tbl_phase[s] = PH_ACT;
                end
                else if (cmd == CMD_CLOSE)
                    tbl_phase[s] = PH_CLOSED;
                return outcome(ST_OK, s);
            end
            CMD_REMOVE:
            begin
                if (id == 0)
                    return outcome(ST_NOT_FOUND, -1);
                if (!ready)
                    return outcome(ST_BAD_STATE, -1);
                s = slot_of(id);
                if (s < 0)
                    return outcome(ST_NOT_FOUND, -1);
                o = outcome(ST_OK, s);
                o.phase = PH_FREE;
                tbl_phase[s] = PH_FREE;
                tbl_id[s] = '0;
                if (occupied > 0)
                    occupied--;
                return o;
            end
            CMD_SHUTDOWN:
            begin
                clear_shadow();
                ready = 1'b0;
                cap_latched = 0;
                return outcome(ST_OK, -1);
            end
            default:
                return outcome(ST_NOT_FOUND, -1);
        endcase
    endfunction

    // check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat");
                failures++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.status)
                begin
                    $error("status: expected %0d actual %0d", e.status, status);
                    failures++;
                end
                if (result_id !== e.rid)
                begin
                    $error("result_id: expected %0h actual %0h", e.rid, result_id);
                    failures++;
                end
                if (slot_index !== e.idx)
                begin
                    $error("slot_index: expected %0d actual %0d", e.idx, slot_index);
                    failures++;
                end
                if (slot_status !== e.phase)
                begin
                    $error("slot_status: expected %0d actual %0d", e.phase, slot_status);
                    failures++;
                end
                if (found !== e.hit)
                begin
                    $error("found: expected %0d actual %0d", e.hit, found);
                    failures++;
                end
            end
        end
    end

    // send one command beat, with a random gap before it in idle_pct percent of calls
    task automatic send_cmd(logic [2:0] cmd, logic [31:0] id);
        if ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(2)) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        command <= cmd;
        session_id <= id;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(table_apply(cmd, id));
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(logic [4:0] val);
        drain();
        @(negedge clk);
        capacity_in_use_we <= 1'b1;
        capacity_in_use <= val;
        cap_reg = val;
        @(negedge clk);
        capacity_in_use_we <= 1'b0;
    endtask

    // mostly IDs that are live in the table, sometimes zero or random
    function automatic logic [31:0] pick_id();
        int r;
        int s;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 20 || occupied == 0)
            return (r & 1) ? $urandom() : next_id + $urandom_range(3);
        s = $urandom_range(cap_latched - 1);
        for (int k = 0; k < NSLOT; k++)
            if (tbl_phase[(s + k) % cap_latched] != PH_FREE)
                return tbl_id[(s + k) % cap_latched];
        return $urandom();
    endfunction

    // commands on a table that was never initialized
    task automatic test_uninitialized();
        send_cmd(CMD_PUBLISH, 32'd0);
        send_cmd(CMD_FIND, 32'd1);
        send_cmd(CMD_ACTIVATE, 32'd1);
        send_cmd(CMD_CLOSE, 32'hFFFF_FFFF);
        send_cmd(CMD_REMOVE, 32'd1);
        send_cmd(CMD_REMOVE, 32'd0);
        send_cmd(3'd7, 32'hFFFF_FFFF);
        send_cmd(CMD_SHUTDOWN, 32'd0);
    endtask

    // lifecycle of a few sessions at full capacity
    task automatic test_lifecycle();
        send_cmd(CMD_INIT, 32'd0);
        send_cmd(CMD_INIT, 32'd0);
        send_cmd(CMD_PUBLISH, 32'd0);
        send_cmd(CMD_PUBLISH, 32'd0);
        send_cmd(CMD_FIND, 32'd1);
        send_cmd(CMD_FIND, 32'd0);
        send_cmd(CMD_FIND, 32'hFFFF_FFFF);
        send_cmd(CMD_ACTIVATE, 32'd1);
        send_cmd(CMD_ACTIVATE, 32'd1);
        send_cmd(CMD_CLOSE, 32'd1);
        send_cmd(CMD_CLOSE, 32'd1);
        send_cmd(CMD_CLOSE, 32'd2);
        send_cmd(CMD_REMOVE, 32'd1);
        send_cmd(CMD_REMOVE, 32'd1);
        send_cmd(CMD_REMOVE, 32'd0);
        send_cmd(CMD_PUBLISH, 32'd0);
        send_cmd(3'd7, 32'd0);
    endtask

    // zero and one usable slot, then a clamped capacity
    task automatic test_capacity_limits();
        write_capacity(5'd0);
        send_cmd(CMD_SHUTDOWN, 32'd0);
        send_cmd(CMD_INIT, 32'd0);
        send_cmd(CMD_PUBLISH, 32'd0);
        write_capacity(5'd1);
        send_cmd(CMD_SHUTDOWN, 32'd0);
        send_cmd(CMD_INIT, 32'd0);
        send_cmd(CMD_PUBLISH, 32'd0);
        send_cmd(CMD_PUBLISH, 32'd0);
        write_capacity(5'd31);
        send_cmd(CMD_SHUTDOWN, 32'd0);
        send_cmd(CMD_INIT, 32'd0);
        repeat (18) send_cmd(CMD_PUBLISH, 32'd0);
        drain();
    endtask

    // random command mix, one capacity setting per phase
    task automatic test_random_phase(int items, logic [4:0] cap, int pct);
        int r;
        write_capacity(cap);
        idle_pct = pct;
        send_cmd(CMD_SHUTDOWN, 32'd0);
        send_cmd(CMD_INIT, 32'd0);
        for (int n = 0; n < items; n++)
        begin
            r = $urandom_range(199);
            if (r < 55)
                send_cmd(CMD_PUBLISH, $urandom());
            else if (r < 90)
                send_cmd(CMD_FIND, pick_id());
            else if (r < 125)
                send_cmd(CMD_ACTIVATE, pick_id());
            else if (r < 150)
                send_cmd(CMD_CLOSE, pick_id());
            else if (r < 185)
                send_cmd(CMD_REMOVE, pick_id());
            else if (r < 191)
                send_cmd(CMD_INIT, $urandom());
            else if (r < 196)
                send_cmd(CMD_SHUTDOWN, $urandom());
            else
                send_cmd(3'd7, $urandom());
            if (n == items / 2)
                drain();
        end
        drain();
    endtask

    initial
    begin
        clear_shadow();
        ready = 1'b0;
        cap_latched = 0;
        cap_reg = CAP_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_uninitialized();
        test_lifecycle();
        test_capacity_limits();
        test_random_phase(550, 5'd16, 9);
        test_random_phase(550, 5'($urandom_range(2, 15)), 85);
        test_random_phase(300, 5'd4, 0);
        test_random_phase(250, 5'd31, 0);

        drain();
        repeat (25) @(posedge clk);
        if (failures == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
